// ===== design/acmi_pkg.sv =====
// Shared constants, types and helpers of the ARGB convolution unit.
`timescale 1ns / 1ps
package acmi_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ORDER = 5;
    localparam int NTAPS     = MAX_ORDER * MAX_ORDER;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int IW_W      = COL_W + 1;
    localparam int ROW_W     = 12;
    localparam int SLOT_W    = $clog2(MAX_ORDER);
    localparam int ORD_W     = 3;
    localparam int TAP_W     = $clog2(NTAPS);
    localparam int RAM_DEPTH = MAX_ORDER * MAX_WIDTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int ACC_W     = 30;
    localparam int NUM_W     = 44;
    localparam int DIV_STEPS = 9;
    localparam int STEP_W    = 4;

    localparam logic [ROW_W-1:0] ROW_SAT = {ROW_W{1'b1}};

    localparam logic FUNC_COEF  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_KERNEL_WIDTH   = 3'd1;
    localparam logic [2:0] REG_KERNEL_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_TARGET_COL     = 3'd3;
    localparam logic [2:0] REG_TARGET_ROW     = 3'd4;
    localparam logic [2:0] REG_DIVISOR        = 3'd5;
    localparam logic [2:0] REG_BIAS           = 3'd6;
    localparam logic [2:0] REG_PRESERVE_ALPHA = 3'd7;

    typedef struct packed {
        logic [IW_W-1:0]  image_width;
        logic [ORD_W-1:0] kernel_width;
        logic [ORD_W-1:0] kernel_height;
        logic [ORD_W-1:0] target_col;
        logic [ORD_W-1:0] target_row;
        logic [15:0]      divisor;
        logic [15:0]      bias;
        logic             preserve_alpha;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_BD,
        S_KT,
        S_NUM,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic mul;
        logic acc;
        logic bd;
        logic kt;
        logic num;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic produce;
        logic tap_last;
        logic div_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [SLOT_W-1:0] ring_inc(input logic [SLOT_W-1:0] s);
        ring_inc = (s == SLOT_W'(MAX_ORDER - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ORD_W-1:0] order_clamp(input logic [ORD_W-1:0] v);
        if (v == '0)
            order_clamp = ORD_W'(1);
        else if (v > ORD_W'(MAX_ORDER))
            order_clamp = ORD_W'(MAX_ORDER);
        else
            order_clamp = v;
    endfunction

endpackage

// ===== design/acmi_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module acmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/acmi_regs.sv =====
// APB configuration registers of the convolution unit.
`timescale 1ns / 1ps
module acmi_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output acmi_pkg::cfg_t cfg
);
    import acmi_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_IMAGE_WIDTH:    cfg_next.image_width    = pwdata[IW_W-1:0];
                REG_KERNEL_WIDTH:   cfg_next.kernel_width   = pwdata[ORD_W-1:0];
                REG_KERNEL_HEIGHT:  cfg_next.kernel_height  = pwdata[ORD_W-1:0];
                REG_TARGET_COL:     cfg_next.target_col     = pwdata[ORD_W-1:0];
                REG_TARGET_ROW:     cfg_next.target_row     = pwdata[ORD_W-1:0];
                REG_DIVISOR:        cfg_next.divisor        = pwdata[15:0];
                REG_BIAS:           cfg_next.bias           = pwdata[15:0];
                REG_PRESERVE_ALPHA: cfg_next.preserve_alpha = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= IW_W'(MAX_WIDTH);
            cfg_reg.kernel_width   <= ORD_W'(3);
            cfg_reg.kernel_height  <= ORD_W'(3);
            cfg_reg.target_col     <= ORD_W'(1);
            cfg_reg.target_row     <= ORD_W'(1);
            cfg_reg.divisor        <= 16'd256;
            cfg_reg.bias           <= 16'd0;
            cfg_reg.preserve_alpha <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_IMAGE_WIDTH:    prdata = 32'(cfg_reg.image_width);
            REG_KERNEL_WIDTH:   prdata = 32'(cfg_reg.kernel_width);
            REG_KERNEL_HEIGHT:  prdata = 32'(cfg_reg.kernel_height);
            REG_TARGET_COL:     prdata = 32'(cfg_reg.target_col);
            REG_TARGET_ROW:     prdata = 32'(cfg_reg.target_row);
            REG_DIVISOR:        prdata = 32'(cfg_reg.divisor);
            REG_BIAS:           prdata = 32'(cfg_reg.bias);
            REG_PRESERVE_ALPHA: prdata = 32'(cfg_reg.preserve_alpha);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== design/acmi_ctrl.sv =====
// Sequencer of the convolution unit: accept, tap loop, divide, deliver.
`timescale 1ns / 1ps
module acmi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  acmi_pkg::dp_status_t   status,
    output acmi_pkg::ctrl_cmd_t    cmd
);
    import acmi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.produce)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:  state_next = S_MUL;
            S_MUL: state_next = S_ACC;
            S_ACC: state_next = status.tap_last ? S_BD : S_RD;
            S_BD:  state_next = S_KT;
            S_KT:  state_next = S_NUM;
            S_NUM: state_next = S_DIV;
            S_DIV: state_next = status.div_last ? S_OUT : S_DIV;
            S_OUT: state_next = status.out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_RD:  cmd.rd       = 1'b1;
            S_MUL: cmd.mul      = 1'b1;
            S_ACC: cmd.acc      = 1'b1;
            S_BD:  cmd.bd       = 1'b1;
            S_KT:  cmd.kt       = 1'b1;
            S_NUM: cmd.num      = 1'b1;
            S_DIV: cmd.div_step = 1'b1;
            S_OUT: cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== design/acmi_dp.sv =====
// Datapath: position counters, line stores, coefficients, MAC lanes and divider.
`timescale 1ns / 1ps
module acmi_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  acmi_pkg::cfg_t       cfg,
    input  acmi_pkg::ctrl_cmd_t  cmd,
    output acmi_pkg::dp_status_t status,
    input  logic                 func,
    input  logic [4:0]           coef_index,
    input  logic [15:0]          coef_value,
    input  logic [31:0]          pixel,
    input  logic                 frame_start,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_pixel,
    output logic [9:0]           out_col,
    output logic [11:0]          out_row
);
    import acmi_pkg::*;

    // Effective configuration.
    logic [IW_W-1:0]  w_eff;
    logic [ORD_W-1:0] kw_eff;
    logic [ORD_W-1:0] kh_eff;
    logic [ORD_W-1:0] tx_eff;
    logic [ORD_W-1:0] ty_eff;

    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = IW_W'(1);
        else if (cfg.image_width > IW_W'(MAX_WIDTH))
            w_eff = IW_W'(MAX_WIDTH);
        else
            w_eff = cfg.image_width;
        kw_eff = order_clamp(cfg.kernel_width);
        kh_eff = order_clamp(cfg.kernel_height);
        tx_eff = (cfg.target_col < kw_eff) ? cfg.target_col : kw_eff - ORD_W'(1);
        ty_eff = (cfg.target_row < kh_eff) ? cfg.target_row : kh_eff - ORD_W'(1);
    end

    // Raster position.
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] ring_reg;
    logic [COL_W-1:0]  col_a;
    logic [ROW_W-1:0]  row_a;
    logic [SLOT_W-1:0] ring_a;
    logic [COL_W-1:0]  cur_c;
    logic [ROW_W-1:0]  cur_r;
    logic [SLOT_W-1:0] cur_ring;
    logic [IW_W-1:0]   col_inc;
    logic              wrap_pre;
    logic              wrap_post;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [SLOT_W-1:0] ring_next;
    logic              take_pix;
    logic              take_coef;

    assign take_pix  = cmd.take && (func == FUNC_PIXEL);
    assign take_coef = cmd.take && (func == FUNC_COEF);

    always_comb
    begin
        col_a    = frame_start ? '0 : col_reg;
        row_a    = frame_start ? '0 : row_reg;
        ring_a   = frame_start ? '0 : ring_reg;
        wrap_pre = {1'b0, col_a} >= w_eff;
        cur_c    = wrap_pre ? '0 : col_a;
        cur_r    = (wrap_pre && row_a != ROW_SAT) ? row_a + ROW_W'(1) : row_a;
        cur_ring = wrap_pre ? ring_inc(ring_a) : ring_a;
        col_inc  = {1'b0, cur_c} + IW_W'(1);
        wrap_post = col_inc >= w_eff;
        col_next  = wrap_post ? '0 : col_inc[COL_W-1:0];
        row_next  = (wrap_post && cur_r != ROW_SAT) ? cur_r + ROW_W'(1) : cur_r;
        ring_next = wrap_post ? ring_inc(cur_ring) : cur_ring;
    end

    assign status.produce = (func == FUNC_PIXEL)
                            && (col_inc >= IW_W'(kw_eff))
                            && ({1'b0, cur_r} + (ROW_W+1)'(1) >= (ROW_W+1)'(kh_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ring_reg <= '0;
        end
        else if (take_pix)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ring_reg <= ring_next;
        end
    end

    logic [COL_W-1:0]  base_c_reg;
    logic [ROW_W-1:0]  base_r_reg;
    logic [SLOT_W-1:0] base_ring_reg;

    always_ff @(posedge clk)
    begin
        if (take_pix)
        begin
            base_c_reg    <= cur_c;
            base_r_reg    <= cur_r;
            base_ring_reg <= cur_ring;
        end
    end

    // Tap walk over the kernel window, row by row.
    logic [ORD_W-1:0] ky_reg;
    logic [ORD_W-1:0] kx_reg;
    logic [TAP_W-1:0] t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ky_reg <= '0;
            kx_reg <= '0;
            t_reg  <= '0;
        end
        else if (cmd.take)
        begin
            ky_reg <= '0;
            kx_reg <= '0;
            t_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            t_reg <= t_reg + TAP_W'(1);
            if (kx_reg == kw_eff - ORD_W'(1))
            begin
                kx_reg <= '0;
                ky_reg <= ky_reg + ORD_W'(1);
            end
            else
            begin
                kx_reg <= kx_reg + ORD_W'(1);
            end
        end
    end

    assign status.tap_last = (ky_reg == kh_eff - ORD_W'(1)) && (kx_reg == kw_eff - ORD_W'(1));

    logic [3:0]        slot_sum;
    logic [SLOT_W-1:0] rd_slot;
    logic [COL_W-1:0]  rd_col;
    logic [RAM_AW-1:0] ram_addr;
    logic [31:0]       ram_rdata;

    always_comb
    begin
        slot_sum = 4'(base_ring_reg) + 4'(MAX_ORDER + 1) - 4'(kh_eff) + 4'(ky_reg);
        rd_slot  = (slot_sum >= 4'(MAX_ORDER)) ? SLOT_W'(slot_sum - 4'(MAX_ORDER))
                                               : SLOT_W'(slot_sum);
        rd_col   = base_c_reg + COL_W'(1) - COL_W'(kw_eff) + COL_W'(kx_reg);
        ram_addr = take_pix ? RAM_AW'({cur_ring, cur_c}) : RAM_AW'({rd_slot, rd_col});
    end

    acmi_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (take_pix),
        .addr  (ram_addr),
        .wdata (pixel),
        .rdata (ram_rdata)
    );

    // Coefficient table.
    logic [15:0] coef_mem [NTAPS];

    always_ff @(posedge clk)
    begin
        if (take_coef && ({1'b0, coef_index} < 6'(NTAPS)))
        begin
            coef_mem[coef_index[TAP_W-1:0]] <= coef_value;
        end
    end

    // Four channel lanes: multiply, accumulate.
    logic signed [24:0]      prod_reg [4];
    logic signed [ACC_W-1:0] acc_reg  [4];
    logic [7:0]              alpha_reg;

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (cmd.mul)
            begin
                prod_reg[l] <= $signed({1'b0, ram_rdata[8*l +: 8]})
                               * $signed(coef_mem[t_reg]);
            end
            if (cmd.take)
            begin
                acc_reg[l] <= '0;
            end
            else if (cmd.acc)
            begin
                acc_reg[l] <= acc_reg[l]
                              + $signed({{(ACC_W-25){prod_reg[l][24]}}, prod_reg[l]});
            end
        end
        if (cmd.mul && ky_reg == ty_eff && kx_reg == tx_eff)
        begin
            alpha_reg <= ram_rdata[31:24];
        end
    end

    // Rounding term and divider.
    logic signed [31:0]      bd_reg;
    logic signed [NUM_W-1:0] k_reg;
    logic [16:0]             dabs_reg;
    logic                    dneg;
    logic                    dzero;
    logic signed [NUM_W-1:0] bd_x;
    logic signed [NUM_W-1:0] d_x;
    logic signed [NUM_W-1:0] kterm;
    logic [16:0]             dext;

    assign dneg  = cfg.divisor[15];
    assign dzero = (cfg.divisor == '0);
    assign dext  = {cfg.divisor[15], cfg.divisor};

    always_comb
    begin
        bd_x  = $signed({{(NUM_W-32){bd_reg[31]}}, bd_reg});
        d_x   = $signed({{(NUM_W-16){cfg.divisor[15]}}, cfg.divisor});
        kterm = (bd_x <<< 8) - bd_x + (d_x <<< 7);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bd)
        begin
            bd_reg <= $signed(cfg.bias) * $signed(cfg.divisor);
        end
        if (cmd.kt)
        begin
            k_reg    <= dneg ? -kterm : kterm;
            dabs_reg <= dneg ? (~dext + 17'd1) : dext;
        end
    end

    logic [NUM_W-1:0]  rem_reg  [4];
    logic [8:0]        q_reg    [4];
    logic [3:0]        zero_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [STEP_W-1:0] step_reg;
    logic signed [NUM_W-1:0] acc_x  [4];
    logic signed [NUM_W-1:0] num_v  [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            acc_x[l] = $signed({{(NUM_W-ACC_W-8){acc_reg[l][ACC_W-1]}}, acc_reg[l], 8'd0});
            num_v[l] = dneg ? (k_reg - acc_x[l]) : (k_reg + acc_x[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.num)
        begin
            dsh_reg <= NUM_W'({dabs_reg, 16'd0});
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[l]  <= num_v[l];
                zero_reg[l] <= num_v[l][NUM_W-1] || dzero;
                q_reg[l]    <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int l = 0; l < 4; l++)
            begin
                if (rem_reg[l] >= dsh_reg)
                begin
                    rem_reg[l] <= rem_reg[l] - dsh_reg;
                    q_reg[l]   <= {q_reg[l][7:0], 1'b1};
                end
                else
                begin
                    q_reg[l] <= {q_reg[l][7:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.num)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign status.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));

    // Output register.
    logic [7:0]  ch [4];
    logic [31:0] res_pixel;
    logic        out_valid_reg;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (zero_reg[l])
                ch[l] = 8'd0;
            else if (q_reg[l][8])
                ch[l] = 8'hFF;
            else
                ch[l] = q_reg[l][7:0];
        end
        res_pixel = {cfg.preserve_alpha ? alpha_reg : ch[3], ch[2], ch[1], ch[0]};
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pixel <= res_pixel;
            out_col   <= base_c_reg + COL_W'(1) - COL_W'(kw_eff) + COL_W'(tx_eff);
            out_row   <= base_r_reg + ROW_W'(1) - ROW_W'(kh_eff) + ROW_W'(ty_eff);
        end
    end

endmodule

// ===== design/argb_convolve_matrix_interior_unit.sv =====
// Top level of the ARGB interior convolution unit.
`timescale 1ns / 1ps
// A coefficient request or a pixel request that yields no output is taken
// without leaving the idle state. A pixel request with an interior output
// passes the shared tap MAC loop (one line store read per tap; a read, a
// multiply and an accumulate step a tap), the rounding setup and the 9-step
// restoring divider before its result is loaded into the output register;
// requests are taken one at a time, and a full output register holds the next
// result back until it drains. Reset clears position counters, controller
// state, output valid and restores register defaults; line stores and
// coefficients are not cleared.
module argb_convolve_matrix_interior_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input requests.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: coef_index[4:0], coef_value[20:5], pixel[52:21], zero fill [55:53]
    input  logic [55:0] s_axis_tdata,
    // tuser: func[0], frame_start[1]
    input  logic [1:0]  s_axis_tuser,
    // Output requests.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_pixel[31:0], out_col[41:32], out_row[53:42], zero fill [55:54]
    output logic [55:0] m_axis_tdata
);
    import acmi_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [31:0] out_pixel;
    logic [9:0]  out_col;
    logic [11:0] out_row;

    // The configuration port never waits.
    assign pready = 1'b1;

    acmi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The controller accepts a request only when idle and walks the taps,
    // the rounding setup and the divider before handing over a result.
    acmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the line stores, the coefficient table, four
    // channel lanes and the output register that decouples the result
    // from the downstream ready.
    acmi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .func        (s_axis_tuser[0]),
        .coef_index  (s_axis_tdata[4:0]),
        .coef_value  (s_axis_tdata[20:5]),
        .pixel       (s_axis_tdata[52:21]),
        .frame_start (s_axis_tuser[1]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_pixel   (out_pixel),
        .out_col     (out_col),
        .out_row     (out_row)
    );

    assign m_axis_tdata = {2'b00, out_row, out_col, out_pixel};

endmodule
